>>> rtl/lfsa_pkg.sv
`default_nettype none

package lfsa_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int FILL_W     = $clog2(MAX_SLOTS + 1);

  localparam int OP_W       = 2;
  localparam int NUM_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_ADD   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NONE_FREE    = 3'd1,
    ST_UNKNOWN      = 3'd2,
    ST_FULL         = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NUMBER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    GRANT_NUM,
    GRANT_ZERO,
    GRANT_RAM
  } grant_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT,
    S_ALLOC,
    S_ALLOC_RD,
    S_FREE_RD,
    S_FREE_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic       latch_req;
    logic       init_start;
    logic       init_step;
    logic       idx_clear;
    logic       idx_load_fill;
    logic       idx_inc;
    logic       alloc_take;
    logic       free_rd;
    logic       free_take;
    logic       add_write;
    logic       set_result;
    status_e    res_status;
    grant_sel_e res_grant;
    logic       rsp_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_lt_fill;
    logic idx_zero;
    logic mark_at_idx;
    logic ram_match;
    logic table_full;
    logic init_done;
    logic rsp_room;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/lfsa_req_if.sv
`default_nettype none

interface lfsa_req_if;
  import lfsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [NUM_W-1:0] slot_num;

  modport source (output valid, output opcode, output slot_num, input ready);
  modport sink (input valid, input opcode, input slot_num, output ready);
endinterface

`default_nettype wire

>>> rtl/lfsa_rsp_if.sv
`default_nettype none

interface lfsa_rsp_if;
  import lfsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NUM_W-1:0]    granted_number;
  logic [CNT_W-1:0]    free_count;
  logic                has_free;
  logic [CNT_W-1:0]    slot_total;

  modport source (
    output valid, output status, output granted_number, output free_count,
    output has_free, output slot_total, input ready
  );
  modport sink (
    input valid, input status, input granted_number, input free_count,
    input has_free, input slot_total, output ready
  );
endinterface

`default_nettype wire

>>> rtl/lfsa_cfg_if.sv
`default_nettype none

interface lfsa_cfg_if;
  import lfsa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lowest_free_slot_allocator.sv
`default_nettype none

// Slot allocator over a table of up to 64 slots, one item at a time. Slot numbers sit in a
// single-port-read RAM; occupied marks, the fill level and the free count are flip-flops.
// Init writes the slot numbers into the RAM, one write per slot. Allocate scans the marks
// one slot per cycle from the bottom up to the lowest free slot, and up to the fill level
// when no slot is free. Free looks up the entries from the top of the table down to the
// matching one, each lookup a RAM read followed by a compare, and goes down to the bottom
// when the number is unknown. The result waits in an output register, and the next item can
// be accepted at the edge after the one that loads it there; while the receiver holds back
// an earlier result, the block waits with the new result pending. Configuration writes are
// always accepted and take effect at the next init.
module lowest_free_slot_allocator (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  lfsa_req_if.sink    req,
  lfsa_rsp_if.source  rsp,
  lfsa_cfg_if.sink    cfg
);
  import lfsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  lfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfsa_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_opcode_i        (req.opcode),
    .req_slot_num_i      (req.slot_num),
    .cfg_we_i            (cfg.valid),
    .cfg_index_i         (cfg.index),
    .cfg_data_i          (cfg.data),
    .rsp_ready_i         (rsp.ready),
    .rsp_valid_o         (rsp.valid),
    .rsp_status_o        (rsp.status),
    .rsp_granted_number_o(rsp.granted_number),
    .rsp_free_count_o    (rsp.free_count),
    .rsp_has_free_o      (rsp.has_free),
    .rsp_slot_total_o    (rsp.slot_total)
  );

endmodule

`default_nettype wire

>>> rtl/lfsa_ram.sv
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0]                                wdata_i,
  input  wire logic                                            re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr_i,
  output logic      [WIDTH-1:0]                                rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lfsa_ctrl.sv
`default_nettype none

module lfsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire lfsa_pkg::sts_t sts_i,
  output lfsa_pkg::cmd_t     cmd_o
);
  import lfsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_INIT: begin
            cmd_o.init_start = 1'b1;
            state_d          = S_INIT;
          end
          OP_ALLOC: begin
            cmd_o.idx_clear = 1'b1;
            state_d         = S_ALLOC;
          end
          OP_FREE: begin
            cmd_o.idx_load_fill = 1'b1;
            state_d             = S_FREE_RD;
          end
          default: begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_grant  = GRANT_NUM;
            if (sts_i.table_full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.add_write  = 1'b1;
              cmd_o.res_status = ST_OK;
            end
            state_d = S_RESP;
          end
        endcase
      end
      S_INIT: begin
        if (sts_i.init_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_grant  = GRANT_NUM;
          state_d          = S_RESP;
        end else begin
          cmd_o.init_step = 1'b1;
        end
      end
      S_ALLOC: begin
        if (!sts_i.idx_lt_fill) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_NONE_FREE;
          cmd_o.res_grant  = GRANT_ZERO;
          state_d          = S_RESP;
        end else if (!sts_i.mark_at_idx) begin
          cmd_o.alloc_take = 1'b1;
          state_d          = S_ALLOC_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_ALLOC_RD: begin
        cmd_o.set_result = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_grant  = GRANT_RAM;
        state_d          = S_RESP;
      end
      S_FREE_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_UNKNOWN;
          cmd_o.res_grant  = GRANT_NUM;
          state_d          = S_RESP;
        end else begin
          cmd_o.free_rd = 1'b1;
          state_d       = S_FREE_CMP;
        end
      end
      S_FREE_CMP: begin
        if (sts_i.ram_match) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_grant  = GRANT_NUM;
          if (sts_i.mark_at_idx) begin
            cmd_o.free_take  = 1'b1;
            cmd_o.res_status = ST_OK;
          end else begin
            cmd_o.res_status = ST_ALREADY_FREE;
          end
          state_d = S_RESP;
        end else begin
          state_d = S_FREE_RD;
        end
      end
      S_RESP: begin
        if (sts_i.rsp_room) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lfsa_datapath.sv
`default_nettype none

module lfsa_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lfsa_pkg::cmd_t                  cmd_i,
  output lfsa_pkg::sts_t                       sts_o,
  input  wire logic [lfsa_pkg::OP_W-1:0]       req_opcode_i,
  input  wire logic [lfsa_pkg::NUM_W-1:0]      req_slot_num_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [lfsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lfsa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            rsp_ready_i,
  output logic                                 rsp_valid_o,
  output logic [lfsa_pkg::STATUS_W-1:0]        rsp_status_o,
  output logic [lfsa_pkg::NUM_W-1:0]           rsp_granted_number_o,
  output logic [lfsa_pkg::CNT_W-1:0]           rsp_free_count_o,
  output logic                                 rsp_has_free_o,
  output logic [lfsa_pkg::CNT_W-1:0]           rsp_slot_total_o
);
  import lfsa_pkg::*;

  // Configuration registers.
  logic [NUM_W-1:0]     first_number_q;
  logic [CNT_W-1:0]     initial_count_q;

  // Latched request.
  op_e                  op_q;
  logic [NUM_W-1:0]     num_q;

  // Table bookkeeping; slot numbers live in the RAM.
  logic [MAX_SLOTS-1:0] marks_q, marks_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W-1:0]    free_q, free_d;

  // Scan and init sweep.
  logic [FILL_W-1:0]    idx_q, idx_d;
  logic [FILL_W-1:0]    init_cnt_q;
  logic [NUM_W-1:0]     init_num_q;

  // Pending result, then the output register.
  status_e              res_status_q;
  logic [NUM_W-1:0]     res_grant_q;
  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [NUM_W-1:0]     rsp_grant_q;
  logic [CNT_W-1:0]     rsp_free_q;
  logic                 rsp_has_free_q;
  logic [CNT_W-1:0]     rsp_total_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [NUM_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [NUM_W-1:0]     ram_rdata;
  logic [FILL_W-1:0]    idx_dec;
  logic [FILL_W-1:0]    init_clamped;

  assign idx_dec      = idx_q - FILL_W'(1);
  assign init_clamped = (int'(initial_count_q) > MAX_SLOTS) ? FILL_W'(MAX_SLOTS)
                                                            : FILL_W'(initial_count_q);

  always_comb begin
    ram_we    = cmd_i.init_step || cmd_i.add_write;
    ram_waddr = cmd_i.init_step ? idx_q[IDX_W-1:0] : fill_q[IDX_W-1:0];
    ram_wdata = cmd_i.init_step ? init_num_q : num_q;
    ram_re    = cmd_i.alloc_take || cmd_i.free_rd;
    ram_raddr = cmd_i.free_rd ? idx_dec[IDX_W-1:0] : idx_q[IDX_W-1:0];
  end

  lfsa_ram #(
    .WIDTH(NUM_W),
    .DEPTH(MAX_SLOTS)
  ) u_numbers (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    marks_d = marks_q;
    fill_d  = fill_q;
    free_d  = free_q;
    idx_d   = idx_q;
    if (cmd_i.init_start) begin
      // Entries are written over the following cycles; nothing reads them before then.
      marks_d = '0;
      fill_d  = init_clamped;
      free_d  = init_clamped;
      idx_d   = '0;
    end
    if (cmd_i.init_step || cmd_i.idx_inc) begin
      idx_d = idx_q + FILL_W'(1);
    end
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end
    if (cmd_i.idx_load_fill) begin
      idx_d = fill_q;
    end
    if (cmd_i.free_rd) begin
      idx_d = idx_dec;
    end
    if (cmd_i.alloc_take) begin
      marks_d[idx_q[IDX_W-1:0]] = 1'b1;
      free_d                    = free_q - FILL_W'(1);
    end
    if (cmd_i.free_take) begin
      marks_d[idx_q[IDX_W-1:0]] = 1'b0;
      free_d                    = free_q + FILL_W'(1);
    end
    if (cmd_i.add_write) begin
      marks_d[fill_q[IDX_W-1:0]] = 1'b0;
      fill_d                     = fill_q + FILL_W'(1);
      free_d                     = free_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_number_q  <= NUM_W'(1);
      initial_count_q <= '0;
      marks_q         <= '0;
      fill_q          <= '0;
      free_q          <= '0;
      rsp_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_FIRST_NUMBER) begin
        first_number_q <= cfg_data_i[NUM_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_INITIAL_COUNT) begin
        initial_count_q <= cfg_data_i[CNT_W-1:0];
      end
      marks_q <= marks_d;
      fill_q  <= fill_d;
      free_q  <= free_d;
      if (cmd_i.rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.latch_req) begin
      op_q  <= op_e'(req_opcode_i);
      num_q <= req_slot_num_i;
    end
    if (cmd_i.init_start) begin
      init_cnt_q <= init_clamped;
      init_num_q <= first_number_q;
    end
    if (cmd_i.init_step) begin
      init_num_q <= init_num_q + NUM_W'(1);
    end
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_grant)
        GRANT_ZERO: res_grant_q <= '0;
        GRANT_RAM:  res_grant_q <= ram_rdata;
        default:    res_grant_q <= num_q;
      endcase
    end
    if (cmd_i.rsp_load) begin
      rsp_status_q   <= res_status_q;
      rsp_grant_q    <= res_grant_q;
      rsp_free_q     <= CNT_W'(free_q);
      rsp_has_free_q <= (free_q != '0);
      rsp_total_q    <= CNT_W'(fill_q);
    end
  end

  always_comb begin
    sts_o.op          = op_q;
    sts_o.idx_lt_fill = (idx_q < fill_q);
    sts_o.idx_zero    = (idx_q == '0);
    sts_o.mark_at_idx = marks_q[idx_q[IDX_W-1:0]];
    sts_o.ram_match   = (ram_rdata == num_q);
    sts_o.table_full  = (fill_q == FILL_W'(MAX_SLOTS));
    sts_o.init_done   = (idx_q == init_cnt_q);
    sts_o.rsp_room    = !rsp_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o          = rsp_valid_q;
  assign rsp_status_o         = rsp_status_q;
  assign rsp_granted_number_o = rsp_grant_q;
  assign rsp_free_count_o     = rsp_free_q;
  assign rsp_has_free_o       = rsp_has_free_q;
  assign rsp_slot_total_o     = rsp_total_q;

endmodule

`default_nettype wire
